>>> rtl/mtsa_pkg.sv
// Package for the two-sorted-array median unit: sizes, widths and state codes.
// Used by mtsa_ram's instantiation in the top level and by the top level itself.
// Has no dependencies.
package mtsa_pkg;

    localparam int DEPTH         = 128;
    localparam int ELEMENT_WIDTH = 16;
    localparam int ADDR_W        = $clog2(DEPTH);
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int SUM_W         = ELEMENT_WIDTH + 1;

    typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;
    typedef logic signed [SUM_W-1:0]         sum_t;
    typedef logic [CNT_W-1:0]                cnt_t;
    typedef logic [ADDR_W-1:0]               addr_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_STEP  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

endpackage

>>> rtl/median_of_two_sorted_arrays_unit.sv
// Top level of the two-sorted-array median unit: load logic, merge sequencer, output register.
// Depends on mtsa_pkg and on mtsa_ram (two instances, one per array store).
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   s_      | in        | s_valid / s_ready  | s_func, s_value, s_last
//   m_      | out       | m_valid / m_ready  | m_median_doubled, m_error
//
// Elements load at one item per cycle. An item with s_last set starts a merge walk
// over both stores that takes n+1 elements in all, each in a RAM read state (ST_FETCH)
// and then a compare state (ST_STEP); the result then passes through ST_EMIT to the output
// register, and an error result goes straight to ST_EMIT. The registered store reads are
// why each element needs its read state. s_ready is low during the walk and while a result
// waits for the output register. Reset is synchronous and active low; it clears both
// element counts and the drop flag, and the stores need no clearing.
module median_of_two_sorted_arrays_unit
    import mtsa_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_func,
    input  logic signed [ELEMENT_WIDTH-1:0] s_value,
    input  logic                     s_last,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [SUM_W-1:0]  m_median_doubled,
    output logic                     m_error
);

    // Sequencer and bookkeeping registers.
    state_t state_reg, state_next;
    cnt_t   first_count_reg, first_count_next;
    cnt_t   second_count_reg, second_count_next;
    logic   overflow_reg, overflow_next;

    // Merge walk: i and j are the heads of the two stores, k counts elements taken.
    cnt_t   n_reg, n_next;
    cnt_t   i_reg, i_next;
    cnt_t   j_reg, j_next;
    cnt_t   k_reg, k_next;
    elem_t  cur_reg, cur_next;

    // Result waiting for the output register, and the output register itself.
    sum_t   res_sum_reg, res_sum_next;
    logic   res_err_reg, res_err_next;
    logic   m_valid_reg, m_valid_next;
    sum_t   m_sum_reg, m_sum_next;
    logic   m_err_reg, m_err_next;

    logic   accept;
    logic   first_full, second_full;
    logic   wr_first, wr_second;
    logic   drop;
    logic   set_error;
    elem_t  first_head, second_head;
    logic   take_first;
    elem_t  taken;
    sum_t   step_sum;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // A full store drops the element and marks the set as bad.
    assign first_full  = (first_count_reg == cnt_t'(DEPTH));
    assign second_full = (second_count_reg == cnt_t'(DEPTH));
    assign wr_first    = accept && !s_func && !first_full;
    assign wr_second   = accept &&  s_func && !second_full;
    assign drop        = accept && (s_func ? second_full : first_full);

    mtsa_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (DEPTH)
    ) u_first_store (
        .aclk    (aclk),
        .wr_en   (wr_first),
        .wr_addr (first_count_reg[ADDR_W-1:0]),
        .wr_data (s_value),
        .rd_addr (i_reg[ADDR_W-1:0]),
        .rd_data (first_head)
    );

    mtsa_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (DEPTH)
    ) u_second_store (
        .aclk    (aclk),
        .wr_en   (wr_second),
        .wr_addr (second_count_reg[ADDR_W-1:0]),
        .wr_data (s_value),
        .rd_addr (j_reg[ADDR_W-1:0]),
        .rd_data (second_head)
    );

    // The single shared compare: the merge takes from the first store on a tie.
    // When a head has run past n its read data is stale and is ignored.
    assign take_first = (j_reg >= n_reg)
                     || ((i_reg < n_reg) && (first_head <= second_head));
    assign taken      = take_first ? first_head : second_head;
    assign step_sum   = sum_t'(cur_reg) + sum_t'(taken);

    always_comb begin
        state_next        = state_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        overflow_next     = overflow_reg;
        n_next            = n_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        k_next            = k_reg;
        cur_next          = cur_reg;
        res_sum_next      = res_sum_reg;
        res_err_next      = res_err_reg;
        m_valid_next      = m_valid_reg;
        m_sum_next        = m_sum_reg;
        m_err_next        = m_err_reg;
        set_error         = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (wr_first) begin
                        first_count_next = first_count_reg + cnt_t'(1);
                    end
                    if (wr_second) begin
                        second_count_next = second_count_reg + cnt_t'(1);
                    end
                    if (drop) begin
                        overflow_next = 1'b1;
                    end
                    if (s_last) begin
                        // The set is closed: judge it, then start afresh for the next one.
                        set_error = (first_count_next != second_count_next)
                                 || (first_count_next == '0)
                                 || overflow_next;
                        n_next            = first_count_next;
                        i_next            = '0;
                        j_next            = '0;
                        k_next            = '0;
                        first_count_next  = '0;
                        second_count_next = '0;
                        overflow_next     = 1'b0;
                        if (set_error) begin
                            res_sum_next = '0;
                            res_err_next = 1'b1;
                            state_next   = ST_EMIT;
                        end else begin
                            state_next   = ST_FETCH;
                        end
                    end
                end
            end
            ST_FETCH: begin
                // Heads at i and j are being read this cycle.
                state_next = ST_STEP;
            end
            ST_STEP: begin
                if (take_first) begin
                    i_next = i_reg + cnt_t'(1);
                end else begin
                    j_next = j_reg + cnt_t'(1);
                end
                cur_next = taken;
                if (k_reg == n_reg) begin
                    // This was element n+1 of the merge; cur holds element n.
                    res_sum_next = step_sum;
                    res_err_next = 1'b0;
                    state_next   = ST_EMIT;
                end else begin
                    k_next     = k_reg + cnt_t'(1);
                    state_next = ST_FETCH;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_sum_next   = res_sum_reg;
                    m_err_next   = res_err_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            overflow_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            overflow_reg     <= overflow_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        k_reg       <= k_next;
        cur_reg     <= cur_next;
        res_sum_reg <= res_sum_next;
        res_err_reg <= res_err_next;
        m_sum_reg   <= m_sum_next;
        m_err_reg   <= m_err_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_median_doubled = m_sum_reg;
    assign m_error          = m_err_reg;

endmodule

>>> rtl/mtsa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; the top level instantiates one per element store.
module mtsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
